// ===== rtl/sidta_pkg.sv =====
// shared constants and types for the signed integer to decimal text converter
`default_nettype none

package sidta_pkg;

	// operand width and derived sizes
	localparam int InputWidth = 32;
	localparam int InTdataW   = ((InputWidth + 7) / 8) * 8;
	// decimal digits needed for the magnitude: floor(w*log10(2)) + 1
	localparam int Digits     = ((InputWidth * 1233) >> 12) + 1;
	localparam int BcdWidth   = 4 * Digits;
	localparam int DigitIdxW  = $clog2(Digits);
	localparam int CntW       = $clog2(InputWidth + 1);

	// result channel
	localparam int OutTdataW  = 8;
	localparam logic [OutTdataW-1:0] CharZero  = 8'h30;
	localparam logic [OutTdataW-1:0] CharMinus = 8'h2D;

	// classified operand passed from front to back
	typedef struct packed {
		logic                  neg;
		logic [InputWidth-1:0] mag;
	} item_t;

endpackage

`default_nettype wire

// ===== rtl/sidta_front.sv =====
// front end: accepts a number and splits it into sign and magnitude
`default_nettype none

module sidta_front (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  [sidta_pkg::InTdataW-1:0]       in_data,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output sidta_pkg::item_t                     out_item
);

	logic                             valid_s1;
	sidta_pkg::item_t                 item_s1;
	logic [sidta_pkg::InputWidth-1:0] raw;
	logic                             neg;

	assign raw      = in_data[sidta_pkg::InputWidth-1:0];
	assign neg      = raw[sidta_pkg::InputWidth-1];
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// magnitude of the most negative value fits as unsigned
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.neg <= neg;
			item_s1.mag <= neg ? (~raw + 1'b1) : raw;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

`default_nettype wire

// ===== rtl/sidta_queue.sv =====
// two-entry queue between front end and converter
`default_nettype none

module sidta_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push_valid,
	output logic                push_ready,
	input  sidta_pkg::item_t    push_item,
	output logic                pop_valid,
	input  wire                 pop_ready,
	output sidta_pkg::item_t    pop_item
);

	sidta_pkg::item_t mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sidta_back.sv =====
// converter: bit-serial binary to bcd, then character emission
`default_nettype none

module sidta_back (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  q_valid,
	output logic                                 q_ready,
	input  sidta_pkg::item_t                     q_item,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic [sidta_pkg::OutTdataW-1:0]      out_char,
	output logic                                 out_last
);

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StConv = 2'd1;
	localparam logic [1:0] StSkip = 2'd2;
	localparam logic [1:0] StEmit = 2'd3;

	logic [1:0]                        st_q;
	logic                              neg_q;
	logic [sidta_pkg::InputWidth-1:0]  sh_q;
	logic [sidta_pkg::BcdWidth-1:0]    bcd_q;
	logic [sidta_pkg::BcdWidth-1:0]    adj;
	logic [sidta_pkg::BcdWidth-1:0]    bcd_nxt;
	logic [sidta_pkg::CntW-1:0]        cnt_q;
	logic [sidta_pkg::DigitIdxW-1:0]   idx_q;
	logic [3:0]                        cur_digit;
	logic                              ovalid_q;
	logic [sidta_pkg::OutTdataW-1:0]   char_q;
	logic                              last_q;
	logic                              out_load;

	// add 3 to every digit of 5 or more, then shift in the next bit
	always_comb begin
		for (int d = 0; d < sidta_pkg::Digits; d++) begin
			adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ? bcd_q[4*d +: 4] + 4'd3
				: bcd_q[4*d +: 4];
		end
	end

	assign bcd_nxt   = {adj[sidta_pkg::BcdWidth-2:0], sh_q[sidta_pkg::InputWidth-1]};
	assign cur_digit = bcd_q[{idx_q, 2'b00} +: 4];
	assign q_ready   = (st_q == StIdle);
	assign out_load  = !ovalid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= StIdle;
			ovalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				ovalid_q <= (st_q == StEmit);
			end
			case (st_q)
				StIdle: begin
					if (q_valid) begin
						st_q <= StConv;
					end
				end
				StConv: begin
					if (cnt_q == sidta_pkg::CntW'(1)) begin
						st_q <= StSkip;
					end
				end
				StSkip: begin
					if (idx_q == '0 || cur_digit != 4'd0) begin
						st_q <= StEmit;
					end
				end
				StEmit: begin
					if (out_load && !neg_q && idx_q == '0) begin
						st_q <= StIdle;
					end
				end
				default: begin
					st_q <= StIdle;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			StIdle: begin
				neg_q <= q_item.neg;
				sh_q  <= q_item.mag;
				bcd_q <= '0;
				cnt_q <= sidta_pkg::CntW'(sidta_pkg::InputWidth);
			end
			StConv: begin
				bcd_q <= bcd_nxt;
				sh_q  <= sh_q << 1;
				cnt_q <= cnt_q - 1'b1;
				idx_q <= sidta_pkg::DigitIdxW'(sidta_pkg::Digits - 1);
			end
			StSkip: begin
				if (idx_q != '0 && cur_digit == 4'd0) begin
					idx_q <= idx_q - 1'b1;
				end
			end
			StEmit: begin
				if (out_load) begin
					if (neg_q) begin
						char_q <= sidta_pkg::CharMinus;
						last_q <= 1'b0;
						neg_q  <= 1'b0;
					end else begin
						char_q <= sidta_pkg::CharZero + {4'b0000, cur_digit};
						last_q <= (idx_q == '0);
						if (idx_q != '0) begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign out_valid = ovalid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

`ifndef SYNTH
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |=> (st_q == StConv))
		else $error("queue pop did not start a conversion");
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && char_q == sidta_pkg::CharMinus) |-> !last_q)
		else $error("minus sign flagged as last character");
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == StEmit && !neg_q) |-> (cur_digit <= 4'd9))
		else $error("bcd digit out of range");
	a_conv_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == StConv) |-> (cnt_q != '0))
		else $error("conversion running with empty bit count");
`endif

endmodule

`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// top level: signed integer to decimal ascii character stream
//
// channel  dir  fields (lsb first)              meaning
// s_axis   in   tdata[31:0] number              one signed integer per request
// m_axis   out  tdata[7:0] char_code, tlast     one character per request,
//                           is_last             tlast on the final character
//
// the front stage registers sign and magnitude, a two-entry queue holds
// pending numbers, the converter pops a number in its idle state,
// shifts one magnitude bit per cycle through a bcd double-dabble register,
// skips leading zeros one digit per cycle, then emits a minus sign if
// needed and one character per cycle while m_axis is ready; it takes no
// new number until the last character of the previous one is in the
// output register.
// reset is asynchronous and active low and empties every stage.
// a stalled m_axis holds the converter; s_axis keeps accepting until
// the front register and the queue are full.
`default_nettype none

module signed_int_to_decimal_ascii (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire  [sidta_pkg::InTdataW-1:0]       s_axis_tdata,   // [31:0] number
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	output logic [sidta_pkg::OutTdataW-1:0]      m_axis_tdata,   // [7:0] char_code
	output logic                                 m_axis_tlast    // is_last
);

	// front to queue
	logic             fr_valid;
	logic             fr_ready;
	sidta_pkg::item_t fr_item;

	// queue to converter
	logic             bk_valid;
	logic             bk_ready;
	sidta_pkg::item_t bk_item;

	// sign and magnitude split
	sidta_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_item  (fr_item)
	);

	// decouples request intake from the slow converter
	sidta_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_item  (fr_item),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_item   (bk_item)
	);

	// bit-serial conversion and character output register
	sidta_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (bk_valid),
		.q_ready   (bk_ready),
		.q_item    (bk_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== bench/tb_signed_int_to_decimal_ascii.sv =====
// self-checking bench for the signed integer to decimal ascii converter
module tb_signed_int_to_decimal_ascii;

	// run limits: the slowest legal run stays well inside the watchdog limit
	localparam int LimitCycles = 400000;
	localparam int LongHold    = 400;
	localparam int TailCycles  = 80;
	localparam int RandomCount = 310;

	// one character of expected text
	typedef struct packed {
		logic [sidta_pkg::OutTdataW-1:0] char_code;
		logic                            is_last;
	} text_char_t;

	// receiver stall patterns
	typedef enum int {
		ReadyAlways,
		ReadyCoin,
		ReadySparse,
		ReadyPattern
	} ready_mode_t;

	// holds the decimal text each accepted number must produce, in order
	class decimal_text_tracker;
		text_char_t pending_chars[$];
		int         errors;

		function new();
			errors = 0;
		endfunction

		// spell an accepted number as ascii: sign, then digits msd first
		function void note_number(logic [sidta_pkg::InputWidth-1:0] number);
			logic                             neg;
			logic [sidta_pkg::InputWidth-1:0] mag;
			logic [3:0]                       digits[$];
			text_char_t                       ch;
			neg = number[sidta_pkg::InputWidth-1];
			// two's complement negate; the most negative value stays in range
			// once the magnitude is read as unsigned
			mag = neg ? (~number + 1'b1) : number;
			do begin
				digits.push_front(4'(mag % 10));
				mag = mag / 10;
			end while (mag != 0);
			if (neg) begin
				ch.char_code = sidta_pkg::CharMinus;
				ch.is_last   = 1'b0;
				pending_chars.push_back(ch);
			end
			foreach (digits[i]) begin
				ch.char_code = sidta_pkg::CharZero + sidta_pkg::OutTdataW'(digits[i]);
				ch.is_last   = (i == digits.size() - 1);
				pending_chars.push_back(ch);
			end
		endfunction

		// compare one accepted character against the oldest expectation
		function void check_char(logic [sidta_pkg::OutTdataW-1:0] char_code, logic is_last);
			text_char_t want;
			if (pending_chars.size() == 0) begin
				$error("unexpected character: char_code %h is_last %b", char_code, is_last);
				errors++;
				return;
			end
			want = pending_chars.pop_front();
			if (char_code !== want.char_code) begin
				$error("char_code mismatch: expected %h, got %h", want.char_code, char_code);
				errors++;
			end
			if (is_last !== want.is_last) begin
				$error("is_last mismatch: expected %b, got %b", want.is_last, is_last);
				errors++;
			end
		endfunction

		function int waiting();
			return pending_chars.size();
		endfunction
	endclass

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	always #6 clk = ~clk;

	// stream signals; the ones the bench drives are known from time zero
	logic                            s_tvalid = 1'b0;
	logic [sidta_pkg::InTdataW-1:0]  s_tdata  = '0;
	logic                            s_tready;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [sidta_pkg::OutTdataW-1:0] m_tdata;
	logic                            m_tlast;

	signed_int_to_decimal_ascii uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),    // [31:0] number
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),    // [7:0] char_code
		.m_axis_tlast  (m_tlast)     // is_last
	);

	decimal_text_tracker text_board = new();

	// long receiver hold-off: the stimulus bumps the ticket count, the
	// receiver serves each ticket with one long stall of its own
	int hold_tickets = 0;
	int hold_served  = 0;
	int cycle_count  = 0;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LimitCycles) begin
			$display("status: fail");
			$finish;
		end
	end

	// result monitor: sample at the rising edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			text_board.check_char(m_tdata, m_tlast);
	end

	// receiver: tready changes at the falling edge, pattern switches now and then
	initial begin
		ready_mode_t mode;
		int          stretch_left;
		int          phase;
		mode         = ReadyAlways;
		stretch_left = 0;
		phase        = 0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_tickets) begin
				// hold off long enough for the block to fill and stall its input
				hold_served++;
				m_tready = 1'b0;
				repeat (LongHold) @(negedge clk);
			end
			if (stretch_left == 0) begin
				mode         = ready_mode_t'($urandom_range(0, 3));
				stretch_left = $urandom_range(10, 200);
			end
			stretch_left--;
			phase++;
			case (mode)
				ReadyAlways:  m_tready = 1'b1;
				ReadyCoin:    m_tready = 1'($urandom_range(0, 1));
				ReadySparse:  m_tready = ($urandom_range(0, 3) == 0);
				ReadyPattern: m_tready = (phase % 5) < 3;
				default:      m_tready = 1'b1;
			endcase
		end
	end

	// offer one number and wait for its request to be taken
	task automatic offer_number(input logic [sidta_pkg::InputWidth-1:0] number);
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = number;
		do @(posedge clk); while (!s_tready);
		text_board.note_number(number);
	endtask

	// drop valid for a number of cycles, with junk on the data lines
	task automatic idle_sender(input int cycles);
		if (cycles == 0)
			return;
		@(negedge clk);
		s_tvalid = 1'b0;
		s_tdata  = $urandom;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// hold the sender until every expected character has come out
	task automatic drain_text();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (text_board.waiting() != 0)
			@(negedge clk);
	endtask

	// random operand: mostly spread over digit counts so every text length
	// shows up, plus raw words, values near the extremes and powers of ten
	function automatic logic [sidta_pkg::InputWidth-1:0] random_number();
		int     kind;
		int     len;
		logic   neg;
		longint lo;
		longint hi;
		longint cap;
		longint mag;
		kind = $urandom_range(0, 9);
		neg  = 1'($urandom_range(0, 1));
		cap  = neg ? 64'd2147483648 : 64'd2147483647;
		if (kind <= 5) begin
			len = $urandom_range(1, 10);
			lo  = 1;
			repeat (len - 1) lo = lo * 10;
			hi  = lo * 10 - 1;
			if (len == 1)
				lo = 0;
			if (hi > cap)
				hi = cap;
			mag = lo + (longint'($urandom) % (hi - lo + 1));
		end else if (kind <= 7) begin
			return $urandom;
		end else if (kind == 8) begin
			mag = cap - $urandom_range(0, 15);
		end else begin
			len = $urandom_range(0, 9);
			lo  = 1;
			repeat (len) lo = lo * 10;
			mag = lo + $urandom_range(0, 2) - 1;
		end
		return neg ? -mag[sidta_pkg::InputWidth-1:0] : mag[sidta_pkg::InputWidth-1:0];
	endfunction

	// random numbers in bursts of random length with random gaps
	task automatic random_bursts(input int count);
		int burst_left;
		burst_left = 0;
		for (int n = 0; n < count; n++) begin
			if (burst_left == 0) begin
				idle_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
				// every so often a long stretch without any gap
				burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
			end
			burst_left--;
			offer_number(random_number());
		end
	endtask

	initial begin
		logic [sidta_pkg::InputWidth-1:0] directed[$];
		int                               fails;

		// extremes, zero, digit-count boundaries and alternating bit patterns
		directed = '{
			32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10,
			32'd99, 32'd100, -32'sd100, 32'd12345, 32'd999999999,
			32'd1000000000, -32'sd1000000000, 32'h7fff_ffff, 32'h8000_0001,
			32'h8000_0000, 32'h7fff_fffe, 32'd1234567890, -32'sd1234567890,
			32'h5555_5555, 32'haaaa_aaaa, 32'd7, -32'sd7
		};

		// hold reset, then release it at a falling edge
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed part, a few gaps thrown in
		foreach (directed[i]) begin
			if ($urandom_range(0, 2) == 0)
				idle_sender($urandom_range(1, 5));
			offer_number(directed[i]);
		end
		drain_text();

		// receiver stalls for a long time while numbers keep coming
		hold_tickets++;
		for (int n = 0; n < 12; n++)
			offer_number(random_number());
		drain_text();

		// random part, with a full drain in the middle
		random_bursts(RandomCount / 2);
		drain_text();
		random_bursts(RandomCount - RandomCount / 2);
		drain_text();

		// let any stray output show up before the verdict
		repeat (TailCycles) @(posedge clk);

		fails = text_board.errors + text_board.waiting();
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sidta_pkg.sv
rtl/sidta_front.sv
rtl/sidta_queue.sv
rtl/sidta_back.sv
rtl/signed_int_to_decimal_ascii.sv
bench/tb_signed_int_to_decimal_ascii.sv
